[sv/frame_deframer_with_ack_tracker_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef FRAME_DEFRAMER_WITH_ACK_TRACKER_MACROS_SVH
`define FRAME_DEFRAMER_WITH_ACK_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fdat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fdat_pkg;

    // Number of entries in the acknowledge table.
    localparam int ACK_ENTRIES = 8;

    // Input modes.
    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_REG  = 2'd1;
    localparam logic [1:0] MODE_POLL = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TYPE_MASK = 2'd0;
    localparam logic [1:0] CFG_DATA_CODE = 2'd1;
    localparam logic [1:0] CFG_ACK_CODE  = 2'd2;
    localparam logic [1:0] CFG_NACK_CODE = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_REG  = 2'd2;
    localparam logic [1:0] KIND_POLL = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_ZERO    = 2'd0;
    localparam logic [1:0] STAT_OK      = 2'd1;
    localparam logic [1:0] STAT_ERR     = 2'd2;
    localparam logic [1:0] STAT_UNKNOWN = 2'd3;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // Acknowledge table entry states.
    typedef enum logic [1:0] {
        ENT_EMPTY = 2'd0,
        ENT_WAIT  = 2'd1,
        ENT_OK    = 2'd2,
        ENT_ERR   = 2'd3
    } ent_state_t;

    // Operation presented to the row of table cells.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_REG  = 2'd1,
        OP_POLL = 2'd2,
        OP_ACK  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] id;
        logic       err;
    } cell_cmd_t;

    // Information rippled from one cell to the next.
    typedef struct packed {
        logic reg_done;
        logic poll_hit;
        logic poll_ok;
        logic wait_seen;
    } cell_chain_t;

    // One result item.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] id;
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic [1:0] status;
    } fdat_res_t;

endpackage

`default_nettype wire

[sv/fdat_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdat_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire fdat_pkg::cell_cmd_t   cmd,
    input  wire fdat_pkg::cell_chain_t chain_in,
    output fdat_pkg::cell_chain_t chain_out,
    output logic                  reg_claim
);
    import fdat_pkg::*;

    ent_state_t state_reg, state_next;
    logic [7:0] id_reg, id_next;
    logic       match;
    logic       answered;
    logic       poll_claim;

    // Entry compares against the id on the command bus.
    assign match      = (state_reg != ENT_EMPTY) && (id_reg == cmd.id);
    assign answered   = (state_reg == ENT_OK) || (state_reg == ENT_ERR);
    assign reg_claim  = (cmd.op == OP_REG) && !chain_in.reg_done
                        && (state_reg == ENT_EMPTY);
    assign poll_claim = (cmd.op == OP_POLL) && !chain_in.poll_hit && match && answered;

    // Pass priority information down the row.
    always_comb
    begin
        chain_out.reg_done  = chain_in.reg_done || (state_reg == ENT_EMPTY);
        chain_out.poll_hit  = chain_in.poll_hit || (match && answered);
        chain_out.poll_ok   = chain_in.poll_hit ? chain_in.poll_ok : (state_reg == ENT_OK);
        chain_out.wait_seen = chain_in.wait_seen || (match && (state_reg == ENT_WAIT));
    end

    // Entry update for register, poll and acknowledge.
    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        if (reg_claim)
        begin
            state_next = ENT_WAIT;
            id_next    = cmd.id;
        end
        else if (poll_claim)
        begin
            state_next = ENT_EMPTY;
        end
        else if ((cmd.op == OP_ACK) && (state_reg == ENT_WAIT) && (id_reg == cmd.id))
        begin
            state_next = cmd.err ? ENT_ERR : ENT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENT_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The id is only looked at while the entry is in use.
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

`default_nettype wire

[sv/fdat_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdat_parser (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 byte_en,
    input  wire  [7:0]          rx_byte,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [7:0]          cfg_data,
    output fdat_pkg::fdat_res_t res,
    output fdat_pkg::cell_cmd_t ack_cmd
);
    import fdat_pkg::*;

    typedef enum logic [3:0] {
        PH_CTRL    = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_ID      = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] cur_id_reg, cur_id_next;
    logic [7:0] type_mask_reg, data_code_reg, ack_code_reg, nack_code_reg;
    logic [7:0] left_dec;
    logic       is_data, is_ack, is_nack;

    // Frame type from the latched control byte; data wins, then ack, then nack.
    assign is_data  = ((ctrl_reg ^ data_code_reg) & type_mask_reg) == 8'd0;
    assign is_ack   = !is_data && (((ctrl_reg ^ ack_code_reg) & type_mask_reg) == 8'd0);
    assign is_nack  = !is_data && !is_ack
                      && (((ctrl_reg ^ nack_code_reg) & type_mask_reg) == 8'd0);
    assign left_dec = left_reg - 8'd1;

    // Frame parser.
    always_comb
    begin
        phase_next  = phase_reg;
        ctrl_next   = ctrl_reg;
        left_next   = left_reg;
        cur_id_next = cur_id_reg;
        res         = '0;
        ack_cmd     = '0;
        ack_cmd.op  = OP_NONE;
        if (byte_en)
        begin
            case (phase_reg)
                PH_CTRL:
                begin
                    ctrl_next  = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (rx_byte == 8'd0)
                    begin
                        phase_next = PH_CTRL;
                    end
                    else
                    begin
                        left_next  = rx_byte;
                        phase_next = PH_ID;
                    end
                end
                PH_ID:
                begin
                    cur_id_next = rx_byte;
                    left_next   = left_dec;
                    phase_next  = (left_dec == 8'd0) ? PH_CTRL : PH_PAYLOAD;
                    if (left_dec == 8'd0)
                    begin
                        if (is_data)
                        begin
                            res.valid = 1'b1;
                            res.kind  = KIND_DATA;
                            res.id    = rx_byte;
                            res.last  = 1'b1;
                        end
                        else if (is_ack || is_nack)
                        begin
                            res.valid   = 1'b1;
                            res.kind    = KIND_ACK;
                            res.id      = rx_byte;
                            res.status  = is_ack ? STAT_OK : STAT_ERR;
                            ack_cmd.op  = OP_ACK;
                            ack_cmd.id  = rx_byte;
                            ack_cmd.err = is_nack;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_CTRL;
                    end
                    if (is_data)
                    begin
                        res.valid      = 1'b1;
                        res.kind       = KIND_DATA;
                        res.id         = cur_id_reg;
                        res.data       = rx_byte;
                        res.data_valid = 1'b1;
                        res.last       = (left_dec == 8'd0);
                    end
                    else if ((is_ack || is_nack) && (left_dec == 8'd0))
                    begin
                        res.valid   = 1'b1;
                        res.kind    = KIND_ACK;
                        res.id      = cur_id_reg;
                        res.status  = is_ack ? STAT_OK : STAT_ERR;
                        ack_cmd.op  = OP_ACK;
                        ack_cmd.id  = cur_id_reg;
                        ack_cmd.err = is_nack;
                    end
                end
                default:
                begin
                    phase_next = PH_CTRL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CTRL;
            ctrl_reg   <= 8'd0;
            left_reg   <= 8'd0;
            cur_id_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ctrl_reg   <= ctrl_next;
            left_reg   <= left_next;
            cur_id_reg <= cur_id_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_mask_reg <= 8'd3;
            data_code_reg <= 8'd1;
            ack_code_reg  <= 8'd2;
            nack_code_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TYPE_MASK: type_mask_reg <= cfg_data;
                CFG_DATA_CODE: data_code_reg <= cfg_data;
                CFG_ACK_CODE:  ack_code_reg  <= cfg_data;
                CFG_NACK_CODE: nack_code_reg <= cfg_data;
                default:       type_mask_reg <= type_mask_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/frame_deframer_with_ack_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "frame_deframer_with_ack_tracker_macros.svh"

// Frame deframer with acknowledge tracker. Each input transfer (a stream byte, a
// register request or a poll request) is handled in the cycle it is accepted,
// so the block takes one item per clock when not stalled and gives at most one
// result per item. Every item sees the acknowledge table in one pass through a
// row of eight cells, each holding one entry; register, poll priority and
// waiting status ripple from the lowest cell to the highest. Results sit in one
// output register; input is stalled only while that register is full and its
// own output is stalled. Configuration is written through the plain write port.
module frame_deframer_with_ack_tracker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [1:0] mode,
    input  wire  [7:0] rx_byte,
    input  wire  [7:0] msg_id,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [1:0] kind,
    output logic [7:0] frame_id,
    output logic [7:0] payload_byte,
    output logic       payload_valid,
    output logic       last,
    output logic [1:0] status,
    input  wire        cfg_we,
    input  wire  [1:0] cfg_index,
    input  wire  [7:0] cfg_data
);
    import fdat_pkg::*;

    logic                   in_accept;
    logic                   out_valid_reg, out_valid_next;
    fdat_res_t              out_reg;
    fdat_res_t              prs_res;
    fdat_res_t              res;
    cell_cmd_t              ack_cmd;
    cell_cmd_t              cmd;
    cell_chain_t            chain [ACK_ENTRIES+1];
    logic [ACK_ENTRIES-1:0] reg_claim;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    fdat_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (in_accept && (mode == MODE_RX)),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (prs_res),
        .ack_cmd   (ack_cmd)
    );

    // Command for the table row.
    always_comb
    begin
        cmd     = '0;
        cmd.op  = OP_NONE;
        if (in_accept)
        begin
            case (mode)
                MODE_RX:   cmd = ack_cmd;
                MODE_REG:  begin cmd.op = OP_REG;  cmd.id = msg_id; end
                MODE_POLL: begin cmd.op = OP_POLL; cmd.id = msg_id; end
                default:   cmd.op = OP_NONE;
            endcase
        end
    end

    // Row of table cells.
    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ACK_ENTRIES; gi++)
        begin : g_cell
            fdat_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1]),
                .reg_claim (reg_claim[gi])
            );
        end
    endgenerate

    // Result of the accepted item.
    always_comb
    begin
        res = '0;
        case (mode)
            MODE_RX:
            begin
                res = prs_res;
            end
            MODE_REG:
            begin
                res.valid  = 1'b1;
                res.kind   = KIND_REG;
                res.id     = msg_id;
                res.status = chain[ACK_ENTRIES].reg_done ? STAT_ZERO : STAT_FULL;
            end
            MODE_POLL:
            begin
                res.valid = 1'b1;
                res.kind  = KIND_POLL;
                res.id    = msg_id;
                if (chain[ACK_ENTRIES].poll_hit)
                begin
                    res.status = chain[ACK_ENTRIES].poll_ok ? STAT_OK : STAT_ERR;
                end
                else
                begin
                    res.status = chain[ACK_ENTRIES].wait_seen ? STAT_ZERO : STAT_UNKNOWN;
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (in_accept && res.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign frame_id      = out_reg.id;
    assign payload_byte  = out_reg.data;
    assign payload_valid = out_reg.data_valid;
    assign last          = out_reg.last;
    assign status        = out_reg.status;

    // Checks on the table row and the output register.
    `FDAT_ASSERT_NOW(a_one_reg_claim, clk, rst_n, 1'b1, $onehot0(reg_claim),
        "more than one cell took a register request")
    `FDAT_ASSERT_NOW(a_stall_needs_full, clk, rst_n, in_stall, out_valid_reg,
        "input stalled with an empty output register")
    `FDAT_ASSERT_NEXT(a_result_loaded, clk, rst_n, in_accept && res.valid, out_valid_reg,
        "result of an accepted item was not loaded")
    `FDAT_ASSERT_NOW(a_payload_is_data, clk, rst_n, out_valid_reg && out_reg.data_valid,
        out_reg.kind == KIND_DATA, "payload flag on a result that is not data")

endmodule

`default_nettype wire
